@@ design/bcc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the bipartite component check: sizes, opcodes, color codes and
// the sequencer state type. It depends on nothing; the top level and the checker import it.
package bcc_pkg;

  localparam int NODE_W    = 10;
  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;

  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int EDGE_AW = $clog2(MAX_EDGES);
  localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
  localparam int SP_W    = $clog2(MAX_NODES + 1);
  localparam int COLOR_W = 2;

  localparam logic [NODE_W:0]     NODE_LIMIT = (NODE_W + 1)'(MAX_NODES);
  localparam logic [ECNT_W-1:0]   EDGE_LIMIT = ECNT_W'(MAX_EDGES);
  localparam logic [SP_W-1:0]     SP_LIMIT   = SP_W'(MAX_NODES);
  localparam logic [NODE_AW-1:0]  NODE_LAST  = NODE_AW'(MAX_NODES - 1);

  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_FINISH   = 1'b1;

  localparam logic [COLOR_W-1:0] COLOR_NONE = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_ONE  = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_TWO  = 2'd2;

  typedef enum logic [9:0] {
    ST_IDLE       = 10'b0000000001,
    ST_CLEAR      = 10'b0000000010,
    ST_SEED       = 10'b0000000100,
    ST_POP        = 10'b0000001000,
    ST_POP_WAIT   = 10'b0000010000,
    ST_CCOL_WAIT  = 10'b0000100000,
    ST_EDGE_ISSUE = 10'b0001000000,
    ST_EDGE_EVAL  = 10'b0010000000,
    ST_HIT_EVAL   = 10'b0100000000,
    ST_DONE       = 10'b1000000000
  } bcc_state_t;

endpackage

@@ design/bcc_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/bipartite_component_check.sv @@
`timescale 1ns / 1ps
// Top level of the bipartite component check: sequencer and the three stores.
// Depends on bcc_pkg and bcc_ram.
//
// Add-edge items are taken one per cycle while the block is idle and are
// appended to a 4096-entry edge store; items with the store full are dropped
// and raise the overflow bit of the next result. A finish item produces
// exactly one result item. Its length is set by the single compare unit and
// the registered-read RAM ports that the sequencer steps through: first a
// clearing pass over the color store of MAX_NODES entries (1024), then a seed
// step, then for every node taken off the walk stack a pop, a stack read and
// a color read, then an issue and an evaluate step per stored edge plus an
// extra step per edge endpoint that matches the node, and finally a pop of
// the empty stack and the loading of the result. The block is not ready
// while a finish item is at work. A result waits in an output register, so
// add-edge items for the next graph can be taken while it is still held.
module bipartite_component_check
  import bcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_bipartite,
  output logic              out_edge_overflow
);

  bcc_state_t state_r, state_nxt;

  logic [ECNT_W-1:0]  edge_cnt_r, edge_cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic [NODE_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SP_W-1:0]    sp_r, sp_nxt;
  logic [NODE_W-1:0]  cur_r, cur_nxt;
  logic [COLOR_W-1:0] ccol_r, ccol_nxt;
  logic [ECNT_W-1:0]  eidx_r, eidx_nxt;
  logic [NODE_W-1:0]  p_r, p_nxt;
  logic [NODE_W-1:0]  q_r, q_nxt;
  logic               hit2_r, hit2_nxt;
  logic               hit_sel_r, hit_sel_nxt;
  logic               ok_r, ok_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_bip_r, out_bip_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  // Edge store: one word per edge, first endpoint in the upper half.
  logic                  edge_we;
  logic [EDGE_AW-1:0]    edge_waddr;
  logic [2*NODE_W-1:0]   edge_wdata;
  logic [EDGE_AW-1:0]    edge_raddr;
  logic [2*NODE_W-1:0]   edge_rdata;

  logic                  col_we;
  logic [NODE_AW-1:0]    col_waddr;
  logic [COLOR_W-1:0]    col_wdata;
  logic [NODE_AW-1:0]    col_raddr;
  logic [COLOR_W-1:0]    col_rdata;

  logic                  stk_we;
  logic [NODE_AW-1:0]    stk_waddr;
  logic [NODE_W-1:0]     stk_wdata;
  logic [NODE_AW-1:0]    stk_raddr;
  logic [NODE_W-1:0]     stk_rdata;

  logic [NODE_W-1:0]     p_now, q_now, nb;
  logic                  hit_p, hit_q;
  logic                  last_edge;
  logic [SP_W-1:0]       sp_dec;
  logic [ECNT_W-1:0]     eidx_inc;
  logic [COLOR_W-1:0]    other_col;

  bcc_ram #(.WIDTH(2 * NODE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  bcc_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_NODES)) u_color_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  bcc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_is_bipartite  = out_bip_r;
  assign out_edge_overflow = out_ovf_r;

  // The shared compare unit: both endpoints of the edge just read against
  // the node being expanded.
  assign p_now = edge_rdata[2*NODE_W-1:NODE_W];
  assign q_now = edge_rdata[NODE_W-1:0];
  assign hit_p = (p_now == cur_r);
  assign hit_q = (q_now == cur_r);

  assign nb        = hit_sel_r ? p_r : q_r;
  assign eidx_inc  = eidx_r + ECNT_W'(1);
  assign last_edge = (eidx_inc >= edge_cnt_r);
  assign sp_dec    = sp_r - SP_W'(1);
  assign other_col = (ccol_r == COLOR_ONE) ? COLOR_TWO : COLOR_ONE;

  assign edge_raddr = eidx_r[EDGE_AW-1:0];
  assign stk_raddr  = sp_dec[NODE_AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    edge_cnt_nxt  = edge_cnt_r;
    ovf_nxt       = ovf_r;
    clr_cnt_nxt   = clr_cnt_r;
    sp_nxt        = sp_r;
    cur_nxt       = cur_r;
    ccol_nxt      = ccol_r;
    eidx_nxt      = eidx_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    hit2_nxt      = hit2_r;
    hit_sel_nxt   = hit_sel_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r;
    out_bip_nxt   = out_bip_r;
    out_ovf_nxt   = out_ovf_r;

    edge_we    = 1'b0;
    edge_waddr = edge_cnt_r[EDGE_AW-1:0];
    edge_wdata = {in_node_a, in_node_b};
    col_we     = 1'b0;
    col_waddr  = clr_cnt_r;
    col_wdata  = COLOR_NONE;
    col_raddr  = '0;
    stk_we     = 1'b0;
    stk_waddr  = sp_r[NODE_AW-1:0];
    stk_wdata  = nb;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // The color read address is issued in the cycle before its data is used.
    case (state_r)
      ST_POP_WAIT:  col_raddr = stk_rdata[NODE_AW-1:0];
      ST_EDGE_EVAL: col_raddr = hit_p ? q_now[NODE_AW-1:0] : p_now[NODE_AW-1:0];
      ST_HIT_EVAL:  col_raddr = p_r[NODE_AW-1:0];
      default:      col_raddr = '0;
    endcase

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_FINISH) begin
            clr_cnt_nxt = '0;
            state_nxt   = ST_CLEAR;
          end else if (({1'b0, in_node_a} < NODE_LIMIT) &&
                       ({1'b0, in_node_b} < NODE_LIMIT)) begin
            if (edge_cnt_r < EDGE_LIMIT) begin
              edge_we      = 1'b1;
              edge_cnt_nxt = edge_cnt_r + ECNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
      end
      ST_CLEAR: begin
        col_we      = 1'b1;
        col_waddr   = clr_cnt_r;
        col_wdata   = COLOR_NONE;
        clr_cnt_nxt = clr_cnt_r + NODE_AW'(1);
        if (clr_cnt_r == NODE_LAST) begin
          state_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        // Node 0 starts with the first color and is the only stack entry.
        col_we    = 1'b1;
        col_waddr = '0;
        col_wdata = COLOR_ONE;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = '0;
        sp_nxt    = SP_W'(1);
        ok_nxt    = 1'b1;
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (sp_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          sp_nxt    = sp_dec;
          state_nxt = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        cur_nxt   = stk_rdata;
        state_nxt = ST_CCOL_WAIT;
      end
      ST_CCOL_WAIT: begin
        ccol_nxt = col_rdata;
        eidx_nxt = '0;
        if (edge_cnt_r == '0) begin
          state_nxt = ST_POP;
        end else begin
          state_nxt = ST_EDGE_ISSUE;
        end
      end
      ST_EDGE_ISSUE: begin
        state_nxt = ST_EDGE_EVAL;
      end
      ST_EDGE_EVAL: begin
        p_nxt = p_now;
        q_nxt = q_now;
        if (hit_p) begin
          hit_sel_nxt = 1'b0;
          hit2_nxt    = hit_q;
          state_nxt   = ST_HIT_EVAL;
        end else if (hit_q) begin
          hit_sel_nxt = 1'b1;
          hit2_nxt    = 1'b0;
          state_nxt   = ST_HIT_EVAL;
        end else if (last_edge) begin
          state_nxt = ST_POP;
        end else begin
          eidx_nxt  = eidx_inc;
          state_nxt = ST_EDGE_ISSUE;
        end
      end
      ST_HIT_EVAL: begin
        if ({1'b0, nb} < NODE_LIMIT) begin
          if (col_rdata == COLOR_NONE) begin
            col_we    = 1'b1;
            col_waddr = nb[NODE_AW-1:0];
            col_wdata = other_col;
            if (sp_r < SP_LIMIT) begin
              stk_we    = 1'b1;
              stk_waddr = sp_r[NODE_AW-1:0];
              stk_wdata = nb;
              sp_nxt    = sp_r + SP_W'(1);
            end
          end else if (col_rdata == ccol_r) begin
            ok_nxt = 1'b0;
          end
        end
        // A second matching endpoint is handled next; its color read was
        // issued in this cycle.
        if (!hit_sel_r && hit2_r) begin
          hit_sel_nxt = 1'b1;
        end else if (last_edge) begin
          state_nxt = ST_POP;
        end else begin
          eidx_nxt  = eidx_inc;
          state_nxt = ST_EDGE_ISSUE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_bip_nxt   = ok_r;
          out_ovf_nxt   = ovf_r;
          edge_cnt_nxt  = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      edge_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clr_cnt_r <= clr_cnt_nxt;
    sp_r      <= sp_nxt;
    cur_r     <= cur_nxt;
    ccol_r    <= ccol_nxt;
    eidx_r    <= eidx_nxt;
    p_r       <= p_nxt;
    q_r       <= q_nxt;
    hit2_r    <= hit2_nxt;
    hit_sel_r <= hit_sel_nxt;
    ok_r      <= ok_nxt;
    out_bip_r <= out_bip_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

endmodule

@@ design/bcc_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the bipartite component check, bound to the top.
// Depends on bcc_pkg and bipartite_component_check.
module bcc_checker
  import bcc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_opcode,
  input logic [NODE_W-1:0] in_node_a,
  input logic [NODE_W-1:0] in_node_b,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_is_bipartite,
  input logic              out_edge_overflow
);

  // A held result keeps its value until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_bipartite) &&
                                $stable(out_edge_overflow))
    else $error("result changed or vanished while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  // An add-edge item never produces a result.
  a_add_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_ADD_EDGE) && !out_valid |=> !out_valid)
    else $error("result appeared after an add-edge item");

  // A finish item starts the walk, so the input side closes.
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_FINISH) |=> !in_ready)
    else $error("input still open after a finish item");

  a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

endmodule

bind bipartite_component_check bcc_checker u_bcc_checker (.*);
